// File: hw/rtl/rti_pkg.sv
// package for the ray / triangle intersection pipeline
// widths, register indexes and the pipeline payload types; no dependencies
`timescale 1ns / 1ps
package rti_pkg;

  localparam int unsigned CoordW = 21;
  localparam int unsigned EdgeW  = CoordW + 1;   // vertex and origin differences
  localparam int unsigned HW     = 2 * CoordW - 7; // cross product after shift
  localparam int unsigned DotW   = 64;
  localparam int unsigned TnW    = 64;
  localparam int unsigned MagW   = 63;            // magnitude of a
  localparam int unsigned QuoW   = 12;            // integer part of t, checked < 2^12
  localparam int unsigned FracW  = 19;            // fraction bits produced by the divider
  localparam int unsigned DistW  = 32;
  localparam int unsigned VertW  = 63;
  localparam int unsigned EpsW   = 24;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    RegVertexA  = 2'd0,
    RegVertexB  = 2'd1,
    RegVertexC  = 2'd2,
    RegDetEps   = 2'd3
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [EdgeW-1:0]  edge_t;

  // what travels through the divider stages of one ray
  typedef struct packed {
    logic              hit;
    logic              neg;
    logic              sat;
    logic [MagW-1:0]   den;
    logic [MagW:0]     rem;
    logic [QuoW-1:0]   lo;    // low dividend bits still to be shifted in
    logic [DistW-1:0]  quo;
  } div_t;

endpackage

// File: hw/rtl/rti_div_stage.sv
// one restoring division step of the distance quotient, registered
// uses rti_pkg
`timescale 1ns / 1ps
module rti_div_stage import rti_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  div_t dat_i,
  output logic vld_o,
  output div_t dat_o
);

  logic  vld_q;
  div_t  dat_q, dat_d;
  logic [MagW+1:0] trial;

  // shift in the next dividend bit and subtract the divisor when it fits
  always_comb begin
    dat_d = dat_i;
    dat_d.lo = {dat_i.lo[QuoW-2:0], 1'b0};
    trial = {dat_i.rem, dat_i.lo[QuoW-1]} - {2'b00, dat_i.den};
    if (!trial[MagW+1]) begin
      dat_d.rem = trial[MagW:0];
      dat_d.quo = {dat_i.quo[DistW-2:0], 1'b1};
    end else begin
      dat_d.rem = {dat_i.rem[MagW-1:0], dat_i.lo[QuoW-1]};
      dat_d.quo = {dat_i.quo[DistW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q <= dat_d;
    end
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// File: hw/rtl/ray_triangle_intersect.sv
// top level of the ray / triangle intersection pipeline
// depends on rti_pkg and rti_div_stage
// 37 register stages from input transfer to result valid
// throughput one ray per cycle unless the output stalls; stages: edges, cross
// products, dot-product terms, sums, sign fix with tests and saturation check,
// one stage per quotient bit (12 integer, 19 fraction) and the output register
// input ready follows output ready in the same cycle; a stall freezes every stage
// reset clears valid bits and loads the config registers with their reset values
`timescale 1ns / 1ps
module ray_triangle_intersect import rti_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // distance
  output logic [OutDataW-1:0] m_axis_tdata,
  // hit
  output logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned NDiv = QuoW + FracW;

  // configuration registers
  logic [VertW-1:0] va_q, vb_q, vc_q;
  logic [EpsW-1:0]  eps_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q  <= '0;
      vb_q  <= '0;
      vc_q  <= '0;
      eps_q <= EpsW'(16);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegVertexA: va_q  <= cfg_data_i[VertW-1:0];
        RegVertexB: vb_q  <= cfg_data_i[VertW-1:0];
        RegVertexC: vc_q  <= cfg_data_i[VertW-1:0];
        RegDetEps:  eps_q <= cfg_data_i[EpsW-1:0];
        default: ;
      endcase
    end
  end

  // global stall: everything moves when the output register can take data
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  function automatic edge_t sub_c(input coord_t x, input coord_t y);
    sub_c = EdgeW'(x) - EdgeW'(y);
  endfunction

  function automatic logic signed [HW-1:0] cross_c(
    input logic signed [EdgeW-1:0] ay, input logic signed [EdgeW-1:0] az,
    input logic signed [EdgeW-1:0] by, input logic signed [EdgeW-1:0] bz);
    logic signed [2*EdgeW:0] p;
    p = (2*EdgeW+1)'(ay * bz) - (2*EdgeW+1)'(az * by);
    cross_c = HW'(p >>> 10);
  endfunction

  // stage 1: edges and s
  logic              v1_q;
  edge_t             e1_q [3], e2_q [3], s_q [3], d1_q [3];
  coord_t            va_c [3], vb_c [3], vc_c [3], org [3], dir [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va_c[k] = va_q[k*CoordW +: CoordW];
      vb_c[k] = vb_q[k*CoordW +: CoordW];
      vc_c[k] = vc_q[k*CoordW +: CoordW];
      org[k]  = s_axis_tdata[k*CoordW +: CoordW];
      dir[k]  = s_axis_tdata[(k+3)*CoordW +: CoordW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= sub_c(vb_c[k], va_c[k]);
        e2_q[k] <= sub_c(vc_c[k], va_c[k]);
        s_q[k]  <= sub_c(org[k], va_c[k]);
        d1_q[k] <= EdgeW'(dir[k]);
      end
    end
  end

  // stage 2: h = dir x e2, q = s x e1
  logic                    v2_q;
  logic signed [HW-1:0]    h_q [3], q_q [3];
  edge_t                   e1b_q [3], e2b_q [3], sb_q [3], d2_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        h_q[k] <= cross_c(d1_q[(k+1)%3], d1_q[(k+2)%3], e2_q[(k+1)%3], e2_q[(k+2)%3]);
        q_q[k] <= cross_c(s_q[(k+1)%3], s_q[(k+2)%3], e1_q[(k+1)%3], e1_q[(k+2)%3]);
      end
      e1b_q <= e1_q;
      e2b_q <= e2_q;
      sb_q  <= s_q;
      d2_q  <= d1_q;
    end
  end

  // stage 3: products of the dot products, one register per multiply
  logic signed [DotW-1:0] pa_q [3], pu_q [3], pv_q [3], pt_q [3];
  logic                   v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        pa_q[k] <= DotW'(e1b_q[k] * h_q[k]);
        pu_q[k] <= DotW'(sb_q[k] * h_q[k]);
        pv_q[k] <= DotW'(d2_q[k] * q_q[k]);
        pt_q[k] <= DotW'(e2b_q[k] * q_q[k]);
      end
    end
  end

  // stage 4: sums
  logic signed [DotW-1:0] a_q, un_q, vn_q, tn_q;
  logic                   v4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q  <= pa_q[0] + pa_q[1] + pa_q[2];
      un_q <= pu_q[0] + pu_q[1] + pu_q[2];
      vn_q <= pv_q[0] + pv_q[1] + pv_q[2];
      tn_q <= pt_q[0] + pt_q[1] + pt_q[2];
    end
  end

  // stage 5: sign fix, determinant and barycentric tests, saturation check
  logic signed [DotW-1:0] aa, un_f, vn_f, tn_f;
  logic [DotW-1:0]        tmag;
  logic                   hit5;
  logic                   sat5;
  logic                   v5_q;
  div_t                   d5_q;

  always_comb begin
    aa   = a_q[DotW-1] ? -a_q : a_q;
    un_f = a_q[DotW-1] ? -un_q : un_q;
    vn_f = a_q[DotW-1] ? -vn_q : vn_q;
    tn_f = a_q[DotW-1] ? -tn_q : tn_q;
    tmag = tn_f[DotW-1] ? DotW'(-tn_f) : DotW'(tn_f);
    hit5 = (a_q != '0) && (aa >= DotW'(eps_q))
        && !un_f[DotW-1] && (un_f <= aa) && !vn_f[DotW-1]
        && ((un_f + vn_f) <= aa);
    // integer part of t of 2^12 or more saturates
    sat5 = {{QuoW{1'b0}}, tmag} >= {aa, {QuoW{1'b0}}};
  end

  // without saturation the top dividend bits are already below the divisor
  always_ff @(posedge clk_i) begin
    if (en) begin
      d5_q.hit <= hit5;
      d5_q.neg <= tn_f[DotW-1];
      d5_q.sat <= sat5;
      d5_q.den <= aa[MagW-1:0];
      d5_q.rem <= (MagW+1)'(tmag >> QuoW);
      d5_q.lo  <= tmag[QuoW-1:0];
      d5_q.quo <= '0;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // quotient bits, integer then fraction, one per stage
  logic vd [NDiv+1];
  div_t dd [NDiv+1];
  assign vd[0] = v5_q;
  assign dd[0] = d5_q;

  for (genvar g = 0; g < NDiv; g++) begin : g_div
    rti_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vd[g]),
      .dat_i  (dd[g]),
      .vld_o  (vd[g+1]),
      .dat_o  (dd[g+1])
    );
  end

  // output register with saturation and sign
  logic [DistW-1:0] dist_d, dist_q;
  logic             hit_q;
  div_t             df;
  assign df = dd[NDiv];

  always_comb begin
    if (!df.hit) begin
      dist_d = '0;
    end else if (df.sat) begin
      dist_d = df.neg ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end else begin
      dist_d = df.neg ? (~df.quo + DistW'(1)) : df.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vd[NDiv];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
      hit_q  <= df.hit;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = dist_q;
  assign m_axis_tuser  = hit_q;

`ifndef SYNTHESIS
  // a miss never carries a distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero distance");
  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // input is taken whenever the output side is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("pipeline stalled with empty output");
`endif

endmodule

// File: tb/sv/ray_triangle_intersect_checker.sv
// result checker for the ray / triangle intersection block
// watches the ray and result streams and the register channel; depends on rti_pkg
`timescale 1ns / 1ps
module ray_triangle_intersect_checker import rti_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [OutDataW-1:0] m_axis_tdata,
  input  logic                m_axis_tuser,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  typedef struct {
    logic             hit;
    logic [DistW-1:0] distance;
  } isect_t;

  logic [VertW-1:0] vert_a, vert_b, vert_c;
  logic [EpsW-1:0]  eps;
  isect_t           expected_q[$];
  int               errors;

  assign errors_o  = errors;
  assign pending_o = expected_q.size();

  function automatic longint sx(logic [63:0] v);
    logic signed [CoordW-1:0] c;
    c = v[CoordW-1:0];
    return longint'(c);
  endfunction

  function automatic vec_t unpack_vert(logic [VertW-1:0] p);
    vec_t r;
    r.x = sx(p);
    r.y = sx(p >> CoordW);
    r.z = sx(p >> (2 * CoordW));
    return r;
  endfunction

  function automatic vec_t vdiff(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  // cross product, arithmetic shift gives floor rounding
  function automatic vec_t cross_floor(vec_t a, vec_t b);
    vec_t r;
    r.x = (a.y * b.z - a.z * b.y) >>> 10;
    r.y = (a.z * b.x - a.x * b.z) >>> 10;
    r.z = (a.x * b.y - a.y * b.x) >>> 10;
    return r;
  endfunction

  function automatic longint dotp(vec_t a, vec_t b);
    return a.x * b.x + a.y * b.y + a.z * b.z;
  endfunction

  function automatic isect_t intersect_ray(logic [InDataW-1:0] d);
    isect_t      r;
    vec_t        va, vb, vc, org, dir, e1, e2, h, s, q;
    longint      a, aa, un, vn, tn;
    logic [63:0] tmag, quo;
    r.hit  = 1'b0;
    r.distance = '0;
    va  = unpack_vert(vert_a);
    vb  = unpack_vert(vert_b);
    vc  = unpack_vert(vert_c);
    org = unpack_vert(d[62:0]);
    dir = unpack_vert(d[125:63]);
    e1  = vdiff(vb, va);
    e2  = vdiff(vc, va);
    h   = cross_floor(dir, e2);
    a   = dotp(e1, h);
    aa  = a < 0 ? -a : a;
    if (a == 0 || aa < longint'(eps)) return r;
    s  = vdiff(org, va);
    un = dotp(s, h);
    q  = cross_floor(s, e1);
    vn = dotp(dir, q);
    tn = dotp(e2, q);
    if (a < 0) begin
      un = -un;
      vn = -vn;
      tn = -tn;
    end
    if (un < 0 || un > aa || vn < 0 || un + vn > aa) return r;
    r.hit = 1'b1;
    tmag  = tn < 0 ? -tn : tn;
    quo   = tmag / aa;
    if (quo >= 64'd4096) begin
      r.distance = tn < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      // 128-bit product keeps the scaled quotient exact
      tmag   = 64'(({64'd0, tmag} << FracW) / {64'd0, aa});
      r.distance = tn < 0 ? 32'(-tmag) : tmag[31:0];
    end
    return r;
  endfunction

  // register shadow, predictions and comparison
  always_ff @(posedge clk_i or negedge rst_ni) begin
    isect_t e;
    if (!rst_ni) begin
      vert_a <= '0;
      vert_b <= '0;
      vert_c <= '0;
      eps    <= 24'd16;
      errors <= 0;
      expected_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          RegVertexA: vert_a <= cfg_data_i[VertW-1:0];
          RegVertexB: vert_b <= cfg_data_i[VertW-1:0];
          RegVertexC: vert_c <= cfg_data_i[VertW-1:0];
          RegDetEps:  eps    <= cfg_data_i[EpsW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(intersect_ray(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_q.pop_front();
          if (m_axis_tuser !== e.hit) begin
            $error("hit: expected %0d actual %0d", e.hit, m_axis_tuser);
            errors <= errors + 1;
          end else if (m_axis_tdata !== e.distance) begin
            $error("distance: expected %h actual %h", e.distance, m_axis_tdata);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/ray_triangle_intersect_tb.sv
// testbench top for the ray / triangle intersection block
// drives rays, register writes and stalls; depends on rti_pkg and the checker
`timescale 1ns / 1ps
module ray_triangle_intersect_tb;
  import rti_pkg::*;

  localparam int Latency = 36;

  logic                clk_i, rst_ni;
  logic                s_axis_tvalid, s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid, m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  int                  errors, pending;
  bit                  long_hold;

  ray_triangle_intersect uut (.*);

  ray_triangle_intersect_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int mode;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        m_axis_tready <= 1'b0;
        repeat (120) @(posedge clk_i);
        long_hold = 1'b0;
      end
      mode = ($urandom_range(0, 255) < 64) ? 0 : $urandom_range(1, 3);
      m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= mode);
    end
  end

  function automatic logic [20:0] rnd_coord(int kind);
    case (kind)
      0: return 21'h0FFFFF;
      1: return 21'h100000;
      2: return 21'($urandom_range(0, 4095)) - 21'd2048;
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] pack3(logic [20:0] x, logic [20:0] y, logic [20:0] z);
    return {z, y, x};
  endfunction

  task automatic cfg_write(cfg_reg_e idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // one ray transfer, with a random gap before it when in a gap phase
  task automatic send_ray(logic [InDataW-1:0] d, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  // well-formed ray aimed inside the triangle, or a random one
  function automatic logic [InDataW-1:0] make_ray(bit aimed);
    logic [20:0] o[3], d[3];
    for (int i = 0; i < 3; i++) begin
      if (aimed) begin
        o[i] = 21'($urandom_range(0, 2047)) - 21'd1024;
        d[i] = 21'($urandom_range(0, 1 << 20)) - 21'(1 << 19);
      end else begin
        o[i] = rnd_coord($urandom_range(0, 3));
        d[i] = rnd_coord($urandom_range(0, 3));
      end
    end
    if (aimed) begin
      o[2] = 21'(-4096 - int'($urandom_range(0, 4096)));
      d[2] = 21'($urandom_range(1 << 18, (1 << 20) - 1));
    end
    return {2'b00, pack3(d[0], d[1], d[2]), pack3(o[0], o[1], o[2])};
  endfunction

  initial begin
    int burst, gap, sent;
    logic [InDataW-1:0] d;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegVertexA;
    cfg_data_i    = '0;
    long_hold     = 1'b0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: degenerate triangle after reset, extremes of every field
    send_ray('0, 0);
    send_ray({2'b00, {126{1'b1}}}, 0);
    send_ray({2'b00, {6{21'h100000}}}, 0);
    send_ray({2'b00, {6{21'h0FFFFF}}}, 0);
    drain();

    // unit triangle in the z=0 plane, epsilon zero
    cfg_write(RegVertexA, pack3(21'h1FFC00, 21'h1FFC00, '0));
    cfg_write(RegVertexB, pack3(21'h000400, 21'h1FFC00, '0));
    cfg_write(RegVertexC, pack3(21'h1FFC00, 21'h000400, '0));
    cfg_write(RegDetEps, 64'd0);
    cfg_write(RegDetEps, 64'hFFFF_FFFF_FF00_0000);  // high bits dropped
    // hit in front, hit behind, parallel, outside, tiny direction saturates
    send_ray({2'b00, pack3('0, '0, 21'h080000), pack3('0, '0, 21'h1FF000)}, 0);
    send_ray({2'b00, pack3('0, '0, 21'h080000), pack3('0, '0, 21'h001000)}, 0);
    send_ray({2'b00, pack3(21'h080000, '0, '0), pack3('0, '0, 21'h1FF000)}, 0);
    send_ray({2'b00, pack3('0, '0, 21'h080000), pack3(21'h000800, 21'h000800,
              21'h1FF000)}, 0);
    send_ray({2'b00, pack3('0, '0, 21'h000001), pack3('0, '0, 21'h100000)}, 0);
    send_ray({2'b00, pack3('0, '0, 21'h1FFFFF), pack3('0, '0, 21'h0FFFFF)}, 0);
    send_ray({2'b00, pack3('0, '0, 21'h100000), pack3(21'h1FFC00, 21'h1FFC00,
              21'h1FF000)}, 0);
    drain();

    // random phases with several triangles and thresholds
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        cfg_write(RegVertexA, {63{1'b1}});
        cfg_write(RegVertexB, 64'h7FFF_FFFF_FFFF_FFFF);
        cfg_write(RegVertexC, '0);
        cfg_write(RegDetEps, 64'hFF_FFFF);
      end else begin
        cfg_write(RegVertexA, pack3(21'($urandom_range(0, 4095)) - 21'd6000,
                  21'($urandom_range(0, 4095)) - 21'd6000, 21'($urandom_range(0, 255))));
        cfg_write(RegVertexB, pack3(21'($urandom_range(2000, 6000)),
                  21'($urandom_range(0, 2047)) - 21'd3000, 21'($urandom_range(0, 255))));
        cfg_write(RegVertexC, pack3(21'($urandom_range(0, 2047)) - 21'd3000,
                  21'($urandom_range(2000, 6000)), 21'($urandom_range(0, 255))));
        cfg_write(RegDetEps, (ph == 0) ? 64'd0 : 64'($urandom_range(0, 1 << 20)));
      end
      if (ph == 2) long_hold = 1'b1;
      while (sent < (ph + 1) * 310) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst; k++) begin
          gap = (k == 0 && $urandom_range(0, 1)) ? $urandom_range(1, 8) : 0;
          d = make_ray($urandom_range(0, 9) < 7);
          send_ray(d, gap);
          sent++;
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
